// ----- rtl/hmfp_pkg.sv -----
// Package for the HTTP message framing parser: payload structs, state codes,
// keyword tables and character helpers. No dependencies.
`default_nettype none
package hmfp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic       message_end;
    logic       past_end;
    logic [1:0] body_mode;
    logic [2:0] message_kind;
  } out_item_t;

  localparam logic [5:0] S_HDR_START     = 6'd0;
  localparam logic [5:0] S_OTHER         = 6'd1;
  localparam logic [5:0] S_CR            = 6'd2;
  localparam logic [5:0] S_CRLF          = 6'd3;
  localparam logic [5:0] S_CRLFCR        = 6'd4;
  localparam logic [5:0] S_CL_BASE       = 6'd4;
  localparam logic [5:0] S_CL_NUM        = 6'd20;
  localparam logic [5:0] S_TE_BASE       = 6'd20;
  localparam logic [5:0] S_CH_BASE       = 6'd38;
  localparam logic [5:0] S_KNOWN         = 6'd46;
  localparam logic [5:0] S_CH_WAIT_CR    = 6'd47;
  localparam logic [5:0] S_CH_CR         = 6'd48;
  localparam logic [5:0] S_CH_SIZE_START = 6'd49;
  localparam logic [5:0] S_CH_SIZE_NUM   = 6'd50;
  localparam logic [5:0] S_CH_SIZE_CR    = 6'd51;
  localparam logic [5:0] S_CH_DATA       = 6'd52;
  localparam logic [5:0] S_INFINITE      = 6'd53;
  localparam logic [5:0] S_DONE          = 6'd54;

  localparam logic [1:0] LS_NONE    = 2'd0;
  localparam logic [1:0] LS_DEC     = 2'd1;
  localparam logic [1:0] LS_BAD     = 2'd2;
  localparam logic [1:0] LS_CHUNKED = 2'd3;

  localparam logic [2:0] K_UNKNOWN  = 3'd0;
  localparam logic [2:0] K_MAYBE    = 3'd1;
  localparam logic [2:0] K_PLAIN    = 3'd2;
  localparam logic [2:0] K_BODY_REQ = 3'd3;
  localparam logic [2:0] K_RESPONSE = 3'd4;

  localparam logic [1:0] M_HEADER   = 2'd0;
  localparam logic [1:0] M_COUNTED  = 2'd1;
  localparam logic [1:0] M_CHUNKED  = 2'd2;
  localparam logic [1:0] M_CLOSE    = 2'd3;

  // Keyword character at a given offset; offset 0 is never used.
  function automatic logic [7:0] kw_cl(input logic [3:0] i);
    case (i)
      4'd1: kw_cl = "o";   4'd2: kw_cl = "n";   4'd3: kw_cl = "t";
      4'd4: kw_cl = "e";   4'd5: kw_cl = "n";   4'd6: kw_cl = "t";
      4'd7: kw_cl = "-";   4'd8: kw_cl = "l";   4'd9: kw_cl = "e";
      4'd10: kw_cl = "n";  4'd11: kw_cl = "g";  4'd12: kw_cl = "t";
      4'd13: kw_cl = "h";  4'd14: kw_cl = ":";
      default: kw_cl = "c";
    endcase
  endfunction

  function automatic logic [7:0] kw_te(input logic [4:0] i);
    case (i)
      5'd1: kw_te = "r";   5'd2: kw_te = "a";   5'd3: kw_te = "n";
      5'd4: kw_te = "s";   5'd5: kw_te = "f";   5'd6: kw_te = "e";
      5'd7: kw_te = "r";   5'd8: kw_te = "-";   5'd9: kw_te = "e";
      5'd10: kw_te = "n";  5'd11: kw_te = "c";  5'd12: kw_te = "o";
      5'd13: kw_te = "d";  5'd14: kw_te = "i";  5'd15: kw_te = "n";
      5'd16: kw_te = "g";  5'd17: kw_te = ":";
      default: kw_te = "t";
    endcase
  endfunction

  function automatic logic [7:0] kw_ch(input logic [2:0] i);
    case (i)
      3'd1: kw_ch = "h";  3'd2: kw_ch = "u";  3'd3: kw_ch = "n";
      3'd4: kw_ch = "k";  3'd5: kw_ch = "e";  3'd6: kw_ch = "d";
      default: kw_ch = "c";
    endcase
  endfunction

  // Letters compare case-insensitively, everything else exactly.
  function automatic logic kw_match(input logic [7:0] k, input logic [7:0] c);
    if (k >= "a" && k <= "z") kw_match = ((c | 8'h20) == k);
    else kw_match = (c == k);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/hmfp_core.sv -----
// Per-byte parser step: next state, count, length status, kind and result
// item from the registered state and one byte. Combinational. Depends on hmfp_pkg.
`default_nettype none
module hmfp_core import hmfp_pkg::*; #(
  parameter int COUNT_BITS = 40
) (
  input  wire logic [7:0]            c,
  input  wire logic [5:0]            s,
  input  wire logic [COUNT_BITS-1:0] cnt,
  input  wire logic [1:0]            ls,
  input  wire logic [2:0]            kind,
  output      logic [5:0]            ns,
  output      logic [COUNT_BITS-1:0] cnt_nxt,
  output      logic [1:0]            ls_nxt,
  output      logic [2:0]            kind_nxt,
  output      out_item_t             res
);

  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [COUNT_BITS-1:0] other_st;
  logic [5:0]  l_other, l_start;
  logic        is_dig, is_hex;
  logic [3:0]  dig, hexd;
  logic [COUNT_BITS+3:0] dec_acc, hex_acc;
  logic [COUNT_BITS-1:0] dec_sat, hex_sat;
  logic        endb, past;

  assign other_st = '0;
  assign l_other = (c == 8'h0d) ? S_CR : S_OTHER;
  assign l_start = ((c | 8'h20) == "c") ? S_CL_BASE + 6'd1 :
                   ((c | 8'h20) == "t") ? S_TE_BASE + 6'd1 : l_other;
  assign is_dig = (c >= "0" && c <= "9");
  assign dig    = 4'(c - "0");

  always_comb begin
    is_hex = 1'b1;
    hexd   = 4'd0;
    if (is_dig) hexd = dig;
    else if (c >= "a" && c <= "f") hexd = 4'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") hexd = 4'(c - "A" + 8'd10);
    else is_hex = 1'b0;
  end

  // Saturating accumulate: x*10+d via multiply, x*16+d via shift.
  assign dec_acc = {4'd0, cnt} * (COUNT_BITS+4)'(10) + (COUNT_BITS+4)'(dig);
  assign hex_acc = {cnt, 4'd0} + (COUNT_BITS+4)'(hexd);
  assign dec_sat = (|dec_acc[COUNT_BITS+3:COUNT_BITS]) ? CMAX : dec_acc[COUNT_BITS-1:0];
  assign hex_sat = (|hex_acc[COUNT_BITS+3:COUNT_BITS]) ? CMAX : hex_acc[COUNT_BITS-1:0];

  always_comb begin
    ns       = s;
    cnt_nxt  = cnt;
    ls_nxt   = ls;
    kind_nxt = kind;
    endb     = 1'b0;
    past     = 1'b0;
    if (s < S_KNOWN) begin
      if (kind == K_UNKNOWN)
        kind_nxt = (c == "H") ? K_MAYBE : ((c == "P") ? K_BODY_REQ : K_PLAIN);
      else if (kind == K_MAYBE)
        kind_nxt = (c == "T") ? K_RESPONSE : K_PLAIN;
    end
    if (s == S_DONE) begin
      endb = 1'b1;
      past = 1'b1;
    end else if (s == S_HDR_START) begin
      ns = l_start;
    end else if (s == S_OTHER) begin
      ns = l_other;
    end else if (s == S_CR) begin
      ns = (c == 8'h0a) ? S_CRLF : l_other;
    end else if (s == S_CRLF) begin
      ns = (c == 8'h0d) ? S_CRLFCR : l_start;
    end else if (s == S_CRLFCR) begin
      if (c == 8'h0a) begin
        if (kind_nxt == K_PLAIN) begin
          cnt_nxt = other_st;
          ns      = S_DONE;
          endb    = 1'b1;
        end else if (ls == LS_CHUNKED) ns = S_CH_SIZE_START;
        else if (ls == LS_DEC && cnt != '0) ns = S_KNOWN;
        else ns = S_INFINITE;
      end else ns = l_other;
    end else if (s > S_CL_BASE && s < S_CL_BASE + 6'd15) begin
      ns = kw_match(kw_cl(4'(s - S_CL_BASE)), c) ? s + 6'd1 : l_other;
    end else if (s == S_CL_BASE + 6'd15) begin
      if (c == " " || c == 8'h09) ns = s;
      else if (is_dig) begin
        cnt_nxt = COUNT_BITS'(dig);
        ls_nxt  = LS_DEC;
        ns      = S_CL_NUM;
      end else ns = l_other;
    end else if (s == S_CL_NUM) begin
      if (is_dig) cnt_nxt = dec_sat;
      else begin
        if (c != 8'h0d) ls_nxt = LS_BAD;
        ns = l_other;
      end
    end else if (s > S_TE_BASE && s < S_TE_BASE + 6'd18) begin
      ns = kw_match(kw_te(5'(s - S_TE_BASE)), c) ? s + 6'd1 : l_other;
    end else if (s == S_TE_BASE + 6'd18) begin
      if (c == " " || c == 8'h09) ns = s;
      else if ((c | 8'h20) == "c") ns = S_CH_BASE + 6'd1;
      else ns = l_other;
    end else if (s > S_CH_BASE && s < S_CH_BASE + 6'd7) begin
      ns = kw_match(kw_ch(3'(s - S_CH_BASE)), c) ? s + 6'd1 : l_other;
    end else if (s == S_CH_BASE + 6'd7) begin
      if (c == " " || c == 8'h09 || c == ";" || c == 8'h0d || c == 8'h0a)
        ls_nxt = LS_CHUNKED;
      ns = l_other;
    end else if (s == S_KNOWN) begin
      if (cnt <= COUNT_BITS'(1)) begin
        cnt_nxt = '0;
        ns      = S_DONE;
        endb    = 1'b1;
      end else cnt_nxt = cnt - COUNT_BITS'(1);
    end else if (s == S_CH_WAIT_CR) begin
      if (c == 8'h0d) ns = S_CH_CR;
    end else if (s == S_CH_CR) begin
      if (c == 8'h0a) ns = S_CH_SIZE_START;
    end else if (s == S_CH_SIZE_START) begin
      cnt_nxt = is_hex ? COUNT_BITS'(hexd) : '0;
      ns      = S_CH_SIZE_NUM;
    end else if (s == S_CH_SIZE_NUM) begin
      if (is_hex) cnt_nxt = hex_sat;
      else if (c == 8'h0d) ns = S_CH_SIZE_CR;
    end else if (s == S_CH_SIZE_CR) begin
      if (c == 8'h0a) begin
        if (cnt == '0) begin
          ns   = S_DONE;
          endb = 1'b1;
        end else ns = S_CH_DATA;
      end
    end else if (s == S_CH_DATA) begin
      if (cnt <= COUNT_BITS'(1)) begin
        cnt_nxt = '0;
        ns      = S_CH_WAIT_CR;
      end else cnt_nxt = cnt - COUNT_BITS'(1);
    end else if (s == S_INFINITE) begin
      ns = s;
    end else begin
      ns = l_other;
    end
  end

  always_comb begin
    res.message_end  = endb;
    res.past_end     = past;
    res.message_kind = kind_nxt;
    if (ns == S_KNOWN) res.body_mode = M_COUNTED;
    else if (ns >= S_CH_WAIT_CR && ns <= S_CH_DATA) res.body_mode = M_CHUNKED;
    else if (ns == S_INFINITE) res.body_mode = M_CLOSE;
    else res.body_mode = M_HEADER;
  end

endmodule
`default_nettype wire

// ----- rtl/http_message_framing_parser.sv -----
// Top level of the HTTP message framing parser: input register, parser
// state, result register. Depends on hmfp_pkg and hmfp_core.
//
// Usage: one byte of the message stream per input transfer on in_valid /
// in_ready / in_data (data_byte, restart). Each byte gives exactly one
// result transfer on out_valid / out_ready / out_data.
// Path: a byte accepted goes through the input register, then through the
// parser step into the result register.
// Throughput: one byte per cycle while the result register is empty or
// out_ready is high; the count update is one 10x or 16x add per byte.
// Reset (rst_n low, synchronous): both stages empty, parser at header start,
// count zero, no length seen, kind unknown.
// Stall: when out_ready is low the result register holds; the input stage
// keeps its byte and in_ready drops only once both stages are full.
// A restart flag clears the parser before its own byte is handled.
`default_nettype none
module http_message_framing_parser import hmfp_pkg::*; #(
  parameter int COUNT_BITS = 40
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire in_item_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_item_t out_data
);

  logic                  a_valid_r;
  in_item_t              a_data_r;
  logic                  o_valid_r;
  out_item_t             o_data_r;
  logic [5:0]            st_r, st_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [1:0]            ls_r, ls_nxt;
  logic [2:0]            kind_r, kind_nxt;
  out_item_t             res;
  logic                  step, a_free;

  logic [5:0]            s_eff;
  logic [COUNT_BITS-1:0] cnt_eff;
  logic [1:0]            ls_eff;
  logic [2:0]            kind_eff;

  assign step     = a_valid_r && (!o_valid_r || out_ready);
  assign a_free   = !a_valid_r || step;
  assign in_ready = a_free;

  // Apply restart before the byte is parsed.
  assign s_eff    = a_data_r.restart ? S_HDR_START : st_r;
  assign cnt_eff  = a_data_r.restart ? '0 : cnt_r;
  assign ls_eff   = a_data_r.restart ? LS_NONE : ls_r;
  assign kind_eff = a_data_r.restart ? K_UNKNOWN : kind_r;

  hmfp_core #(.COUNT_BITS(COUNT_BITS)) u_core (
    .c        (a_data_r.data_byte),
    .s        (s_eff),
    .cnt      (cnt_eff),
    .ls       (ls_eff),
    .kind     (kind_eff),
    .ns       (st_nxt),
    .cnt_nxt  (cnt_nxt),
    .ls_nxt   (ls_nxt),
    .kind_nxt (kind_nxt),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
      st_r      <= S_HDR_START;
      cnt_r     <= '0;
      ls_r      <= LS_NONE;
      kind_r    <= K_UNKNOWN;
    end else begin
      if (a_free) a_valid_r <= in_valid;
      if (step) begin
        o_valid_r <= 1'b1;
        st_r      <= st_nxt;
        cnt_r     <= cnt_nxt;
        ls_r      <= ls_nxt;
        kind_r    <= kind_nxt;
      end else if (out_ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && in_valid) a_data_r <= in_data;
    if (step) o_data_r <= res;
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

  a_past_implies_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.past_end || out_data.message_end))
    else $error("past_end without message_end");

  a_end_header_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.message_end) |-> (out_data.body_mode == M_HEADER))
    else $error("finished message reports a body mode");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE) |-> (kind_r != K_UNKNOWN))
    else $error("message finished with unknown kind");

endmodule
`default_nettype wire
